[hdl/fcv_pkg.sv]
// fcv_pkg: shared types, constants and the byte-wide crc step for the frame validator
`default_nettype none

package fcv_pkg;

    // frame geometry
    localparam int FRAME_BYTES      = 42;
    localparam int HEADER_SUM_BYTES = 16;
    localparam int POS_W            = 6;

    // fixed layout offsets
    localparam logic [POS_W-1:0] POS_IDENT_HI  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_IDENT_LO  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SEQUENCE  = POS_W'(6);
    localparam logic [POS_W-1:0] POS_HDR_CHECK = POS_W'(16);
    localparam logic [POS_W-1:0] POS_PACKET_ID = POS_W'(17);
    localparam logic [POS_W-1:0] POS_SUM_END   = POS_W'(HEADER_SUM_BYTES);
    localparam logic [POS_W-1:0] POS_CHK_LOW   = POS_W'(FRAME_BYTES - 2);

    // crc and identifier constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  IDENT_HI = 8'h5A;
    localparam logic [7:0]  IDENT_LO = 8'hA5;

    // register reset value
    localparam logic [7:0] PACKET_ID_RESET = 8'h02;

    // verdict codes
    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_CRC       = 3'd1,
        VERDICT_IDENT     = 3'd2,
        VERDICT_HDR_SUM   = 3'd3,
        VERDICT_PACKET_ID = 3'd4
    } t_verdict;

    // result of one processed byte
    typedef struct packed {
        logic       valid;
        t_verdict   verdict;
        logic [7:0] frame_sequence;
    } t_result;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/fcv_if.sv]
// fcv_rx_if and fcv_res_if: valid/ready channels for received bytes and verdicts
`default_nettype none

interface fcv_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface fcv_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [7:0] frame_sequence;

    modport source (output valid, output verdict, output frame_sequence, input ready);
    modport sink   (input valid, input verdict, input frame_sequence, output ready);
endinterface

`default_nettype wire

[hdl/fcv_frame_check.sv]
// fcv_frame_check: per-frame state, crc, header sum and verdict for one byte per step
`default_nettype none

module fcv_frame_check import fcv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_frame_start,
    input  logic [7:0]    i_accepted_packet_id,
    output t_result       o_result
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_sum, n_sum;
    logic             r_ident_ok, n_ident_ok;
    logic [7:0]       r_hdr_check, n_hdr_check;
    logic [7:0]       r_packet_id, n_packet_id;
    logic [7:0]       r_sequence, n_sequence;
    logic [7:0]       r_chk_low, n_chk_low;

    logic [POS_W-1:0] pos;
    logic [15:0]      crc_cur;
    logic [7:0]       sum_cur;
    logic             ident_cur;
    logic [15:0]      got_crc;
    logic             last_byte;

    // start flag restarts the running values for this byte
    always_comb begin
        pos       = i_frame_start ? '0 : r_pos;
        crc_cur   = i_frame_start ? CRC_INIT : r_crc;
        sum_cur   = i_frame_start ? 8'h00 : r_sum;
        ident_cur = i_frame_start ? 1'b0 : r_ident_ok;
    end

    // field capture, sums and crc
    always_comb begin
        n_sum       = (pos < POS_SUM_END) ? sum_cur + i_rx_byte : sum_cur;
        n_ident_ok  = ident_cur;
        if (pos == POS_IDENT_HI) begin
            n_ident_ok = (i_rx_byte == IDENT_HI);
        end else if (pos == POS_IDENT_LO) begin
            n_ident_ok = ident_cur && (i_rx_byte == IDENT_LO);
        end
        n_sequence  = (pos == POS_SEQUENCE)  ? i_rx_byte : r_sequence;
        n_hdr_check = (pos == POS_HDR_CHECK) ? i_rx_byte : r_hdr_check;
        n_packet_id = (pos == POS_PACKET_ID) ? i_rx_byte : r_packet_id;
        n_chk_low   = (pos == POS_CHK_LOW)   ? i_rx_byte : r_chk_low;
        n_crc       = (pos < POS_CHK_LOW) ? crc_feed(crc_cur, i_rx_byte) : crc_cur;
        last_byte   = (pos > POS_CHK_LOW);
        n_pos       = last_byte ? '0 : pos + POS_W'(1);
    end

    // verdict on the last byte, first failing check decides
    always_comb begin
        got_crc                 = {i_rx_byte, r_chk_low};
        o_result.valid          = i_step && last_byte;
        o_result.frame_sequence = n_sequence;
        priority if (~crc_cur != got_crc) begin
            o_result.verdict = VERDICT_CRC;
        end else if (!n_ident_ok) begin
            o_result.verdict = VERDICT_IDENT;
        end else if (n_sum != n_hdr_check) begin
            o_result.verdict = VERDICT_HDR_SUM;
        end else if (n_packet_id != i_accepted_packet_id) begin
            o_result.verdict = VERDICT_PACKET_ID;
        end else begin
            o_result.verdict = VERDICT_OK;
        end
    end

    // frame state, restarted after a verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_sum       <= 8'h00;
            r_ident_ok  <= 1'b0;
            r_hdr_check <= 8'h00;
            r_packet_id <= 8'h00;
            r_sequence  <= 8'h00;
            r_chk_low   <= 8'h00;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_crc       <= last_byte ? CRC_INIT : n_crc;
            r_sum       <= last_byte ? 8'h00 : n_sum;
            r_ident_ok  <= last_byte ? 1'b0 : n_ident_ok;
            r_hdr_check <= n_hdr_check;
            r_packet_id <= n_packet_id;
            r_sequence  <= n_sequence;
            r_chk_low   <= n_chk_low;
        end
    end

endmodule

`default_nettype wire

[hdl/fixed_frame_crc_header_validator_top.sv]
// fixed_frame_crc_header_validator_top: byte input register, frame check, verdict register
//
// channel   | dir | handshake    | payload
// i_rx      | in  | valid/ready  | rx_byte[7:0], frame_start
// o_res     | out | valid/ready  | verdict[2:0], frame_sequence[7:0]
// i_cfg_*   | in  | write enable | accepted_packet_id[7:0]
//
// one byte per cycle sustained while the verdict register is free or being drained;
// the last byte of a frame passes through the input register, then the frame check
// loads its verdict into the verdict register, from which the verdict transfers out.
// synchronous active-low reset clears frame state and sets packet id to 2.
// a stalled verdict holds in its register; the input register keeps taking
// bytes until it is also full, then ready drops.
`default_nettype none

module fixed_frame_crc_header_validator_top import fcv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    fcv_rx_if.sink      i_rx,
    fcv_res_if.source   o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_out_valid;
    t_verdict   r_out_verdict;
    logic [7:0] r_out_sequence;
    logic [7:0] r_packet_id;
    logic       advance;
    t_result    result;

    // pipeline moves when the verdict register is free or being drained
    assign advance    = !r_out_valid || o_res.ready;
    assign i_rx.ready = !r_in_valid || advance;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_id <= PACKET_ID_RESET;
        end else if (i_cfg_we) begin
            r_packet_id <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte  <= i_rx.rx_byte;
            r_in_start <= i_rx.frame_start;
        end
    end

    fcv_frame_check u_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_step               (r_in_valid && advance),
        .i_rx_byte            (r_in_byte),
        .i_frame_start        (r_in_start),
        .i_accepted_packet_id (r_packet_id),
        .o_result             (result)
    );

    // verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out_verdict  <= result.verdict;
            r_out_sequence <= result.frame_sequence;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.verdict        = r_out_verdict;
    assign o_res.frame_sequence = r_out_sequence;

    // a produced verdict always lands in the verdict register
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance && result.valid |=> r_out_valid)
        else $error("verdict lost between check and output register");

    // a held input byte is not overwritten while the pipeline is stalled
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_start))
        else $error("input register changed during stall");

    // only defined verdict codes leave the block
    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_verdict <= VERDICT_PACKET_ID)
        else $error("undefined verdict code");

endmodule

`default_nettype wire
